[hw/rtl/csvs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CSV field splitter package
// Shared widths, register indexes and reset values for the field splitter.
// ----------------------------------------------------------------------------
package csvs_pkg;

  // Longest delimiter sequence that is honored; longer lengths saturate here.
  localparam int unsigned MaxSequence = 4;

  // Default number of field bytes kept for suffix matching.
  localparam int unsigned HistoryDepthDef = 8;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned SeqW     = 32;
  localparam int unsigned SeqBytes = SeqW / ByteW;
  localparam int unsigned LenW     = 3;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    RegSepBytes  = 8'd0,
    RegSepLen    = 8'd1,
    RegQuoteBytes = 8'd2,
    RegQuoteLen  = 8'd3,
    RegEscBytes  = 8'd4,
    RegEscLen    = 8'd5,
    RegEolBytes  = 8'd6,
    RegEolLen    = 8'd7
  } cfg_reg_e;

  // Reset values of the configuration registers.
  localparam logic [SeqW-1:0] SepBytesRst   = 32'd44;
  localparam logic [LenW-1:0] SepLenRst     = 3'd1;
  localparam logic [SeqW-1:0] QuoteBytesRst = 32'd34;
  localparam logic [LenW-1:0] QuoteLenRst   = 3'd1;
  localparam logic [SeqW-1:0] EscBytesRst   = 32'd92;
  localparam logic [LenW-1:0] EscLenRst     = 3'd1;
  localparam logic [SeqW-1:0] EolBytesRst   = 32'd10;
  localparam logic [LenW-1:0] EolLenRst     = 3'd1;

  // One result transaction.
  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             inside_quotes;
    logic             field_done;
    logic             line_done;
    logic [LenW-1:0]  trim_count;
  } result_t;

endpackage
`default_nettype wire

[hw/rtl/csvs_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CSV field splitter channels
// Valid/ready channels for input bytes, results and configuration writes.
// ----------------------------------------------------------------------------

// Input byte channel.
interface csvs_byte_if;
  import csvs_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// Result channel.
interface csvs_result_if;
  import csvs_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             inside_quotes;
  logic             field_done;
  logic             line_done;
  logic [LenW-1:0]  trim_count;

  modport source (output valid, output out_byte, output inside_quotes,
                  output field_done, output line_done, output trim_count,
                  input ready);
  modport sink   (input valid, input out_byte, input inside_quotes,
                  input field_done, input line_done, input trim_count,
                  output ready);
endinterface

// Configuration write channel.
interface csvs_cfg_if;
  import csvs_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/csv_field_splitter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CSV field splitter
// Splits a delimited-text byte stream into fields and lines. Each input byte
// yields one result carrying the byte, the quote state and close flags.
// ----------------------------------------------------------------------------
// Output: a result is registered and becomes valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the output register is reloaded in the same
// cycle its transaction completes, so ready only drops while a result stalls.
// Reset: configuration returns to comma, double quote, backslash and line
// feed, each one byte long; the field history, count and quote flag clear.
module csv_field_splitter
  import csvs_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = csvs_pkg::HistoryDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  csvs_byte_if.sink        in_ch,
  csvs_result_if.source    out_ch,
  csvs_cfg_if.sink         cfg_ch
);

  localparam int unsigned CntW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(HISTORY_DEPTH);

  // Configuration registers.
  logic [SeqW-1:0] sep_bytes_q, quote_bytes_q, esc_bytes_q, eol_bytes_q;
  logic [LenW-1:0] sep_len_q, quote_len_q, esc_len_q, eol_len_q;

  // Field state.
  logic [ByteW-1:0] hist_q [HISTORY_DEPTH];
  logic [ByteW-1:0] hist_d [HISTORY_DEPTH];
  logic [CntW-1:0]  cnt_q, cnt_d, cnt_inc;
  logic             quote_q, quote_d;

  // Output register.
  logic    out_valid_q;
  result_t res_q, res_d;

  logic in_fire;
  logic [LenW-1:0] sep_len, quote_len, esc_len, eol_len;
  logic quote_hit, esc_hit, sep_hit, eol_hit;

  // Saturate a programmed length at the longest supported sequence.
  function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] len);
    logic [LenW-1:0] res;
    if (int'(len) > int'(MaxSequence)) begin
      res = LenW'(MaxSequence);
    end else begin
      res = len;
    end
    return res;
  endfunction

  // True when the sequence ends off bytes before the newest field byte.
  function automatic logic ends_at(input logic [ByteW-1:0] h [HISTORY_DEPTH],
                                   input logic [CntW-1:0] cnt,
                                   input logic [SeqW-1:0] seq,
                                   input logic [LenW-1:0] len,
                                   input logic [LenW-1:0] off);
    int unsigned l;
    int unsigned o;
    int unsigned k;
    logic [ByteW-1:0] sb;
    logic ok;
    l  = int'(len);
    o  = int'(off);
    ok = (l != 0) && (o + l <= int'(cnt));
    for (int unsigned p = 0; p < HISTORY_DEPTH; p++) begin
      if (p >= o && p < o + l) begin
        k = l - 1 - (p - o);
        if (k >= SeqBytes) begin
          sb = '0;
        end else begin
          sb = ByteW'(seq >> (ByteW * k));
        end
        if (h[p] != sb) begin
          ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

  // Handshakes: a byte is taken whenever the output register is free or drains.
  assign in_ch.ready  = !out_valid_q || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign sep_len   = clamp_len(sep_len_q);
  assign quote_len = clamp_len(quote_len_q);
  assign esc_len   = clamp_len(esc_len_q);
  assign eol_len   = clamp_len(eol_len_q);

  // Shift the new byte into the history and count it.
  always_comb begin
    hist_d[0] = in_ch.data_byte;
    for (int unsigned i = 1; i < HISTORY_DEPTH; i++) begin
      hist_d[i] = hist_q[i-1];
    end
    cnt_inc = (cnt_q == CntMax) ? cnt_q : cnt_q + CntW'(1);
  end

  // Suffix matches against the updated field history.
  assign quote_hit = ends_at(hist_d, cnt_inc, quote_bytes_q, quote_len, '0);
  assign esc_hit   = (esc_len != '0) &&
                     ends_at(hist_d, cnt_inc, esc_bytes_q, esc_len, quote_len);
  assign sep_hit   = ends_at(hist_d, cnt_inc, sep_bytes_q, sep_len, '0);
  assign eol_hit   = ends_at(hist_d, cnt_inc, eol_bytes_q, eol_len, '0);

  // Quote toggle, then field or line close outside quotes.
  always_comb begin
    quote_d = quote_q ^ (quote_hit && !esc_hit);
    cnt_d   = cnt_inc;
    res_d.out_byte      = in_ch.data_byte;
    res_d.inside_quotes = quote_d;
    res_d.field_done    = 1'b0;
    res_d.line_done     = 1'b0;
    res_d.trim_count    = '0;
    if (!quote_d) begin
      if (sep_hit) begin
        res_d.field_done = 1'b1;
        res_d.trim_count = sep_len;
        cnt_d            = '0;
      end else if (eol_hit) begin
        res_d.line_done  = 1'b1;
        res_d.trim_count = eol_len;
        cnt_d            = '0;
      end
    end
  end

  // Field state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      quote_q <= 1'b0;
      for (int unsigned i = 0; i < HISTORY_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
    end else if (in_fire) begin
      cnt_q   <= cnt_d;
      quote_q <= quote_d;
      for (int unsigned i = 0; i < HISTORY_DEPTH; i++) begin
        hist_q[i] <= hist_d[i];
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_q <= in_ch.valid;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.out_byte      = res_q.out_byte;
  assign out_ch.inside_quotes = res_q.inside_quotes;
  assign out_ch.field_done    = res_q.field_done;
  assign out_ch.line_done     = res_q.line_done;
  assign out_ch.trim_count    = res_q.trim_count;

  // Configuration register writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_bytes_q   <= SepBytesRst;
      sep_len_q     <= SepLenRst;
      quote_bytes_q <= QuoteBytesRst;
      quote_len_q   <= QuoteLenRst;
      esc_bytes_q   <= EscBytesRst;
      esc_len_q     <= EscLenRst;
      eol_bytes_q   <= EolBytesRst;
      eol_len_q     <= EolLenRst;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        RegSepBytes:   sep_bytes_q   <= cfg_ch.data[SeqW-1:0];
        RegSepLen:     sep_len_q     <= cfg_ch.data[LenW-1:0];
        RegQuoteBytes: quote_bytes_q <= cfg_ch.data[SeqW-1:0];
        RegQuoteLen:   quote_len_q   <= cfg_ch.data[LenW-1:0];
        RegEscBytes:   esc_bytes_q   <= cfg_ch.data[SeqW-1:0];
        RegEscLen:     esc_len_q     <= cfg_ch.data[LenW-1:0];
        RegEolBytes:   eol_bytes_q   <= cfg_ch.data[SeqW-1:0];
        RegEolLen:     eol_len_q     <= cfg_ch.data[LenW-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire
